/* rtl/core/sdle_pkg.sv */
`default_nettype none
package sdle_pkg;

  localparam int unsigned DefaultEntries  = 16;
  localparam int unsigned DefaultKeyWidth = 32;

  typedef enum logic [1:0] {
    KIND_SORTED = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_MEMBER     = 2'd1,
    ERR_NOT_MEMBER = 2'd2
  } err_e;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_CURS   = 9'b000000100,
    ST_WALK   = 9'b000001000,
    ST_LINK_A = 9'b000010000,
    ST_LINK_B = 9'b000100000,
    ST_UNLINK = 9'b001000000,
    ST_HEAD   = 9'b010000000,
    ST_RESP   = 9'b100000000
  } state_e;

  // Enables for the node store; addresses and data travel beside it.
  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
    logic key_we;
    logic clear;
  } store_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/sdle_node_store.sv */
`default_nettype none
module sdle_node_store #(
  parameter int unsigned ENTRIES   = sdle_pkg::DefaultEntries,
  parameter int unsigned KEY_WIDTH = sdle_pkg::DefaultKeyWidth,
  parameter int unsigned NW        = $clog2(ENTRIES + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire sdle_pkg::store_ctrl_t   ctrl_i,
  input  wire logic [NW-1:0]           rd_addr_i,
  input  wire logic [NW-1:0]           next_waddr_i,
  input  wire logic [NW-1:0]           next_wdata_i,
  input  wire logic [NW-1:0]           prev_waddr_i,
  input  wire logic [NW-1:0]           prev_wdata_i,
  input  wire logic [NW-1:0]           key_waddr_i,
  input  wire logic [KEY_WIDTH-1:0]    key_wdata_i,
  output logic      [NW-1:0]           next_rd_o,
  output logic      [NW-1:0]           prev_rd_o,
  output logic      [KEY_WIDTH-1:0]    key_rd_o,
  output logic      [NW-1:0]           head_o,
  output logic      [NW-1:0]           tail_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [NW-1:0] Sent = NW'(ENTRIES);

  logic [NW-1:0]        next_mem [ENTRIES];
  logic [NW-1:0]        prev_mem [ENTRIES];
  logic [KEY_WIDTH-1:0] key_mem  [ENTRIES];

  logic [NW-1:0] head_q, head_d;
  logic [NW-1:0] tail_q, tail_d;
  logic [NW-1:0] next_rd_q;
  logic [NW-1:0] prev_rd_q;
  logic [KEY_WIDTH-1:0] key_rd_q;

  // The sentinel's links live in registers; every other node lives in memory.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clear) begin
      head_d = Sent;
      tail_d = Sent;
    end else begin
      if (ctrl_i.next_we && next_waddr_i == Sent) begin
        head_d = next_wdata_i;
      end
      if (ctrl_i.prev_we && prev_waddr_i == Sent) begin
        tail_d = prev_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= Sent;
      tail_q <= Sent;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.next_we && next_waddr_i != Sent) begin
      next_mem[next_waddr_i[IW-1:0]] <= next_wdata_i;
    end
    if (ctrl_i.prev_we && prev_waddr_i != Sent) begin
      prev_mem[prev_waddr_i[IW-1:0]] <= prev_wdata_i;
    end
    if (ctrl_i.key_we) begin
      key_mem[key_waddr_i[IW-1:0]] <= key_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      next_rd_q <= next_mem[rd_addr_i[IW-1:0]];
      prev_rd_q <= prev_mem[rd_addr_i[IW-1:0]];
      key_rd_q  <= key_mem[rd_addr_i[IW-1:0]];
    end
  end

  assign next_rd_o = next_rd_q;
  assign prev_rd_o = prev_rd_q;
  assign key_rd_o  = key_rd_q;
  assign head_o    = head_q;
  assign tail_o    = tail_q;

endmodule
`default_nettype wire

/* rtl/core/sorted_delay_list_engine_unit.sv */
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   kind_i, handle_i, key_i
// out      output     out_valid_o / out_ready_i count_o, head_valid_o, head_handle_o,
//                                               head_key_o, error_code_o
//
// One item is in flight at a time; in_ready_o is high only while idle.
// Clear and rejected items pass from a check state to the head read and the response;
// remove adds an unlink state, and insert before cursor adds a cursor read (skipped off
// the sentinel) and two link states. Sorted insert walks the list on the node store's
// single read port, comparing one entry per walk state, before the same two link states.
// Reset restores the empty list at once; a held result stalls the input until taken.
module sorted_delay_list_engine_unit #(
  parameter int unsigned ENTRIES   = sdle_pkg::DefaultEntries,
  parameter int unsigned KEY_WIDTH = sdle_pkg::DefaultKeyWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  handle_i,
  input  wire logic [31:0] key_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [4:0]  count_o,
  output logic             head_valid_o,
  output logic      [3:0]  head_handle_o,
  output logic      [31:0] head_key_o,
  output logic      [1:0]  error_code_o
);

  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [NW-1:0] Sent = NW'(ENTRIES);
  localparam logic [KEY_WIDTH-1:0] KeyMask = {KEY_WIDTH{1'b1}};

  sdle_pkg::state_e state_q, state_d;
  sdle_pkg::kind_e  kind_q, kind_d;
  sdle_pkg::err_e   err_q, err_d;
  logic [3:0]           hraw_q, hraw_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [NW-1:0]        at_q, at_d;
  logic [NW-1:0]        nx_q, nx_d;
  logic [NW-1:0]        cursor_q, cursor_d;
  logic [CW-1:0]        count_q, count_d;
  logic [ENTRIES-1:0]   member_q, member_d;

  sdle_pkg::store_ctrl_t ctrl;
  logic [NW-1:0]        rd_addr;
  logic [NW-1:0]        next_waddr, next_wdata;
  logic [NW-1:0]        prev_waddr, prev_wdata;
  logic [NW-1:0]        next_rd, prev_rd, head, tail;
  logic [KEY_WIDTH-1:0] key_rd;

  logic          h_ok;
  logic [NW-1:0] hidx;
  logic          is_member;

  assign h_ok      = 32'(hraw_q) < ENTRIES;
  assign hidx      = NW'(hraw_q);
  assign is_member = h_ok && member_q[hidx[IW-1:0]];

  sdle_node_store #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH),
    .NW       (NW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .rd_addr_i   (rd_addr),
    .next_waddr_i(next_waddr),
    .next_wdata_i(next_wdata),
    .prev_waddr_i(prev_waddr),
    .prev_wdata_i(prev_wdata),
    .key_waddr_i (hidx),
    .key_wdata_i (key_q),
    .next_rd_o   (next_rd),
    .prev_rd_o   (prev_rd),
    .key_rd_o    (key_rd),
    .head_o      (head),
    .tail_o      (tail)
  );

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    err_d      = err_q;
    hraw_d     = hraw_q;
    key_d      = key_q;
    at_d       = at_q;
    nx_d       = nx_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    member_d   = member_q;
    ctrl       = '0;
    rd_addr    = hidx;
    next_waddr = hidx;
    next_wdata = nx_q;
    prev_waddr = hidx;
    prev_wdata = at_q;

    case (state_q)
      sdle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = sdle_pkg::kind_e'(kind_i);
          hraw_d  = handle_i;
          key_d   = KEY_WIDTH'(key_i);
          err_d   = sdle_pkg::ERR_NONE;
          state_d = sdle_pkg::ST_CHECK;
        end
      end
      sdle_pkg::ST_CHECK: begin
        case (kind_q)
          sdle_pkg::KIND_CLEAR: begin
            member_d   = '0;
            cursor_d   = Sent;
            count_d    = '0;
            ctrl.clear = 1'b1;
            state_d    = sdle_pkg::ST_HEAD;
          end
          sdle_pkg::KIND_REMOVE: begin
            if (!is_member) begin
              err_d   = sdle_pkg::ERR_NOT_MEMBER;
              state_d = sdle_pkg::ST_HEAD;
            end else begin
              ctrl.rd_en = 1'b1;
              rd_addr    = hidx;
              state_d    = sdle_pkg::ST_UNLINK;
            end
          end
          sdle_pkg::KIND_CURSOR: begin
            if (!h_ok || is_member) begin
              err_d   = sdle_pkg::ERR_MEMBER;
              state_d = sdle_pkg::ST_HEAD;
            end else begin
              nx_d = cursor_q;
              if (cursor_q == Sent) begin
                at_d    = tail;
                state_d = sdle_pkg::ST_LINK_A;
              end else begin
                ctrl.rd_en = 1'b1;
                rd_addr    = cursor_q;
                state_d    = sdle_pkg::ST_CURS;
              end
            end
          end
          sdle_pkg::KIND_SORTED: begin
            if (!h_ok || is_member) begin
              err_d   = sdle_pkg::ERR_MEMBER;
              state_d = sdle_pkg::ST_HEAD;
            end else if (key_q == KeyMask) begin
              // The forever key goes straight to the tail.
              at_d    = tail;
              nx_d    = Sent;
              state_d = sdle_pkg::ST_LINK_A;
            end else begin
              at_d = Sent;
              nx_d = head;
              if (head == Sent) begin
                state_d = sdle_pkg::ST_LINK_A;
              end else begin
                ctrl.rd_en = 1'b1;
                rd_addr    = head;
                state_d    = sdle_pkg::ST_WALK;
              end
            end
          end
          default: begin
            state_d = sdle_pkg::ST_HEAD;
          end
        endcase
      end
      sdle_pkg::ST_CURS: begin
        at_d    = prev_rd;
        state_d = sdle_pkg::ST_LINK_A;
      end
      sdle_pkg::ST_WALK: begin
        // key_rd and next_rd belong to node nx_q, which is never the sentinel here.
        if (key_rd <= key_q) begin
          at_d = nx_q;
          nx_d = next_rd;
          if (next_rd == Sent) begin
            state_d = sdle_pkg::ST_LINK_A;
          end else begin
            ctrl.rd_en = 1'b1;
            rd_addr    = next_rd;
          end
        end else begin
          state_d = sdle_pkg::ST_LINK_A;
        end
      end
      sdle_pkg::ST_LINK_A: begin
        ctrl.next_we = 1'b1;
        ctrl.prev_we = 1'b1;
        ctrl.key_we  = 1'b1;
        next_waddr   = hidx;
        next_wdata   = nx_q;
        prev_waddr   = hidx;
        prev_wdata   = at_q;
        state_d      = sdle_pkg::ST_LINK_B;
      end
      sdle_pkg::ST_LINK_B: begin
        ctrl.next_we = 1'b1;
        ctrl.prev_we = 1'b1;
        next_waddr   = at_q;
        next_wdata   = hidx;
        prev_waddr   = nx_q;
        prev_wdata   = hidx;
        member_d[hidx[IW-1:0]] = 1'b1;
        count_d      = count_q + CW'(1);
        state_d      = sdle_pkg::ST_HEAD;
      end
      sdle_pkg::ST_UNLINK: begin
        ctrl.next_we = 1'b1;
        ctrl.prev_we = 1'b1;
        next_waddr   = prev_rd;
        next_wdata   = next_rd;
        prev_waddr   = next_rd;
        prev_wdata   = prev_rd;
        if (cursor_q == hidx) begin
          cursor_d = prev_rd;
        end
        member_d[hidx[IW-1:0]] = 1'b0;
        count_d      = count_q - CW'(1);
        state_d      = sdle_pkg::ST_HEAD;
      end
      sdle_pkg::ST_HEAD: begin
        if (head != Sent) begin
          ctrl.rd_en = 1'b1;
          rd_addr    = head;
        end
        state_d = sdle_pkg::ST_RESP;
      end
      sdle_pkg::ST_RESP: begin
        if (out_ready_i) begin
          state_d = sdle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdle_pkg::ST_IDLE;
      cursor_q <= Sent;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    err_q  <= err_d;
    hraw_q <= hraw_d;
    key_q  <= key_d;
    at_q   <= at_d;
    nx_q   <= nx_d;
  end

  logic [31:0]          count_wide;
  logic [31:0]          head_wide;
  logic [63:0]          head_key_wide;
  logic                 nonempty;

  assign nonempty      = head != Sent;
  assign count_wide    = 32'(count_q);
  assign head_wide     = 32'(head);
  assign head_key_wide = nonempty ? 64'(key_rd) : 64'(KeyMask);

  assign in_ready_o    = state_q == sdle_pkg::ST_IDLE;
  assign out_valid_o   = state_q == sdle_pkg::ST_RESP;
  assign count_o       = count_wide[4:0];
  assign head_valid_o  = nonempty;
  assign head_handle_o = nonempty ? head_wide[3:0] : 4'd0;
  assign head_key_o    = head_key_wide[31:0];
  assign error_code_o  = err_q;

endmodule
`default_nettype wire

/* verif/sdle_list_checker.sv */
module sdle_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  handle_i,
  input  logic [31:0] key_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  count_i,
  input  logic        head_valid_i,
  input  logic [3:0]  head_handle_i,
  input  logic [31:0] head_key_i,
  input  logic [1:0]  error_code_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = sdle_pkg::DefaultEntries;
  localparam logic [4:0]  Sentinel = 5'(Entries);
  localparam logic [31:0] Forever = '1;

  typedef struct packed {
    logic [4:0]      count;
    logic            head_valid;
    logic [3:0]      head_handle;
    logic [31:0]     head_key;
    sdle_pkg::err_e  error_code;
  } head_report_t;

  logic [31:0] key_tbl [Entries];
  logic [4:0]  next_tbl [Entries + 1];
  logic [4:0]  prev_tbl [Entries + 1];
  logic        member_tbl [Entries];
  logic [4:0]  cursor;
  logic [4:0]  member_count;

  head_report_t expected_heads [$];
  int           fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic empty_list();
    for (int i = 0; i < Entries; i++) begin
      member_tbl[i] = 1'b0;
    end
    next_tbl[Sentinel] = Sentinel;
    prev_tbl[Sentinel] = Sentinel;
    cursor = Sentinel;
    member_count = '0;
  endtask

  function automatic logic [31:0] node_key(logic [4:0] node);
    return (node == Sentinel) ? Forever : key_tbl[node[3:0]];
  endfunction

  task automatic apply_list_edit(input sdle_pkg::kind_e kind, input logic [3:0] handle,
                                 input logic [31:0] key, output head_report_t rep);
    logic [4:0]     h;
    logic [4:0]     at;
    logic [4:0]     pv;
    logic [4:0]     nx;
    logic [4:0]     hd;
    int             steps;
    sdle_pkg::err_e err;
    h = {1'b0, handle};
    err = sdle_pkg::ERR_NONE;
    case (kind)
      sdle_pkg::KIND_CLEAR: begin
        empty_list();
      end
      sdle_pkg::KIND_REMOVE: begin
        if (!member_tbl[handle]) begin
          err = sdle_pkg::ERR_NOT_MEMBER;
        end else begin
          pv = prev_tbl[h];
          nx = next_tbl[h];
          prev_tbl[nx] = pv;
          next_tbl[pv] = nx;
          if (cursor == h) begin
            cursor = pv;
          end
          member_tbl[handle] = 1'b0;
          member_count--;
        end
      end
      default: begin
        if (member_tbl[handle]) begin
          err = sdle_pkg::ERR_MEMBER;
        end else begin
          key_tbl[handle] = key;
          if (kind == sdle_pkg::KIND_CURSOR) begin
            at = prev_tbl[cursor];
          end else if (key == Forever) begin
            at = prev_tbl[Sentinel];
          end else begin
            // Ties land after older entries; the sentinel always stops the walk.
            at = Sentinel;
            steps = 0;
            while (steps <= Entries && node_key(next_tbl[at]) <= key) begin
              at = next_tbl[at];
              steps++;
            end
          end
          nx = next_tbl[at];
          next_tbl[h] = nx;
          prev_tbl[nx] = h;
          prev_tbl[h] = at;
          next_tbl[at] = h;
          member_tbl[handle] = 1'b1;
          member_count++;
        end
      end
    endcase
    hd = next_tbl[Sentinel];
    rep.count = member_count;
    rep.head_valid = (hd != Sentinel);
    rep.head_handle = (hd != Sentinel) ? hd[3:0] : 4'd0;
    rep.head_key = node_key(hd);
    rep.error_code = err;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    head_report_t rep;
    head_report_t want;
    if (!rst_ni) begin
      empty_list();
      expected_heads.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_heads.size() == 0) begin
          $display("%0t: result item with nothing expected, count %0d head %0h key %0h",
                   $time, count_i, head_handle_i, head_key_i);
          fail_count++;
        end else begin
          want = expected_heads.pop_front();
          check_field("count", 32'(want.count), 32'(count_i));
          check_field("head_valid", 32'(want.head_valid), 32'(head_valid_i));
          check_field("head_handle", 32'(want.head_handle), 32'(head_handle_i));
          check_field("head_key", want.head_key, head_key_i);
          check_field("error_code", 32'(want.error_code), 32'(error_code_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_list_edit(sdle_pkg::kind_e'(kind_i), handle_i, key_i, rep);
        expected_heads.push_back(rep);
      end
      pending_o <= expected_heads.size();
    end
  end

endmodule

/* verif/tb_sorted_delay_list_engine_unit.sv */
module tb_sorted_delay_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [3:0]  handle_i = '0;
  logic [31:0] key_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  count_o;
  logic        head_valid_o;
  logic [3:0]  head_handle_o;
  logic [31:0] head_key_o;
  logic [1:0]  error_code_o;

  int   fail_count;
  int   pending;
  logic no_idle = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  sorted_delay_list_engine_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .handle_i,
    .key_i,
    .out_valid_o,
    .out_ready_i,
    .count_o,
    .head_valid_o,
    .head_handle_o,
    .head_key_o,
    .error_code_o
  );

  sdle_list_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .kind_i,
    .handle_i,
    .key_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .count_i      (count_o),
    .head_valid_i (head_valid_o),
    .head_handle_i(head_handle_o),
    .head_key_i   (head_key_o),
    .error_code_i (error_code_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic offer_item(input sdle_pkg::kind_e kind, input logic [3:0] handle,
                            input logic [31:0] key);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    handle_i <= handle;
    key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[sorted_delay_list_engine_unit] ERROR");
    $finish;
  end

  initial begin
    int              roll;
    int              mix;
    sdle_pkg::kind_e kind;
    logic [31:0]     key;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(sdle_pkg::KIND_CLEAR, 4'd0, 32'd0);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd5, 32'd0);
    offer_item(sdle_pkg::KIND_SORTED, 4'd0, 32'd0);
    offer_item(sdle_pkg::KIND_SORTED, 4'd15, 32'hFFFF_FFFF);
    offer_item(sdle_pkg::KIND_SORTED, 4'd1, 32'd0);
    offer_item(sdle_pkg::KIND_SORTED, 4'd2, 32'hFFFF_FFFF);
    offer_item(sdle_pkg::KIND_SORTED, 4'd3, 32'hFFFF_FFFE);
    offer_item(sdle_pkg::KIND_CURSOR, 4'd4, 32'h1234_5678);
    offer_item(sdle_pkg::KIND_SORTED, 4'd0, 32'd5);
    offer_item(sdle_pkg::KIND_CURSOR, 4'd15, 32'd7);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd0, 32'd0);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd0, 32'd0);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd15, 32'd0);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd4, 32'd0);
    offer_item(sdle_pkg::KIND_CURSOR, 4'd7, 32'hAAAA_5555);
    offer_item(sdle_pkg::KIND_SORTED, 4'd8, 32'h5555_AAAA);
    offer_item(sdle_pkg::KIND_CLEAR, 4'd15, 32'hFFFF_FFFF);
    offer_item(sdle_pkg::KIND_CURSOR, 4'd9, 32'd0);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd9, 32'd0);
    offer_item(sdle_pkg::KIND_SORTED, 4'd10, 32'hFFFF_FFFF);
    offer_item(sdle_pkg::KIND_REMOVE, 4'd11, 32'd0);
    offer_item(sdle_pkg::KIND_CLEAR, 4'd0, 32'd0);

    for (int n = 0; n < 950; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) begin
        hold_go = 1'b1;
      end
      // Alternate insert-heavy and remove-heavy stretches so the list both
      // fills up completely and drains back to empty.
      roll = $urandom_range(99);
      mix = (n / 100) % 2;
      if (mix == 0) begin
        kind = (roll < 55) ? sdle_pkg::KIND_SORTED : (roll < 75) ? sdle_pkg::KIND_CURSOR :
               (roll < 98) ? sdle_pkg::KIND_REMOVE : sdle_pkg::KIND_CLEAR;
      end else begin
        kind = (roll < 30) ? sdle_pkg::KIND_SORTED : (roll < 40) ? sdle_pkg::KIND_CURSOR :
               (roll < 97) ? sdle_pkg::KIND_REMOVE : sdle_pkg::KIND_CLEAR;
      end
      case ($urandom_range(9))
        0: key = 32'd0;
        1: key = 32'hFFFF_FFFF;
        2: key = 32'hFFFF_FFFE;
        3, 4, 5: key = 32'($urandom_range(7));
        default: key = $urandom;
      endcase
      offer_item(kind, 4'($urandom_range(15)), key);
    end
    in_valid_i <= 1'b0;

    // The checker's pending count is registered, so poll it only after the next edge.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[sorted_delay_list_engine_unit] OK");
    end else begin
      $display("[sorted_delay_list_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sdle_pkg.sv
rtl/core/sdle_node_store.sv
rtl/core/sorted_delay_list_engine_unit.sv
verif/sdle_list_checker.sv
verif/tb_sorted_delay_list_engine_unit.sv
